>>> src/bsc_pkg.sv
// Package: shared types, constants and helpers for the barometric compensation pipeline
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgW    = 48;
  localparam int RawW    = 20;
  localparam int DivW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP  = 2'd0,
    REG_PRESA = 2'd1,
    REG_PRESB = 2'd2,
    REG_PRESC = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                   input int k);
    logic signed [31:0] bias;
    begin
      bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      sdiv_pow2 = (v + bias) >>> k;
    end
  endfunction

endpackage
`default_nettype wire

>>> src/barometric_sensor_compensation.sv
// Pipeline: 9 front stages, 33 divider stages, 3 correction stages and an output register.
// Throughput: one request per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage.
// The 32-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset (rst_n low, synchronous) clears valid bits and calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation import bsc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [RawW-1:0]     in_raw_temperature,
  input  wire logic [RawW-1:0]     in_raw_pressure,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_temperature_centi,
  output logic [31:0]              out_pressure_pa,
  output logic                     out_divisor_zero,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data
);

  logic [CfgW-1:0] reg_r [4];
  coef_t coef;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) reg_r[i] <= '0;
    end else if (cfg_valid) begin
      reg_r[cfg_index] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  assign coef.t1 = reg_r[REG_TEMP][15:0];
  assign coef.t2 = reg_r[REG_TEMP][31:16];
  assign coef.t3 = reg_r[REG_TEMP][47:32];
  assign coef.p1 = reg_r[REG_PRESA][15:0];
  assign coef.p2 = reg_r[REG_PRESA][31:16];
  assign coef.p3 = reg_r[REG_PRESA][47:32];
  assign coef.p4 = reg_r[REG_PRESB][15:0];
  assign coef.p5 = reg_r[REG_PRESB][31:16];
  assign coef.p6 = reg_r[REG_PRESB][47:32];
  assign coef.p7 = reg_r[REG_PRESC][15:0];
  assign coef.p8 = reg_r[REG_PRESC][31:16];
  assign coef.p9 = reg_r[REG_PRESC][47:32];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic        f_vld;
  logic [31:0] f_temp, f_pres, f_div;
  bsc_front u_front (
    .clk, .rst_n, .en,
    .in_vld (in_valid && in_ready),
    .in_ut  (in_raw_temperature),
    .in_up  (in_raw_pressure),
    .coef,
    .out_vld (f_vld), .out_temp (f_temp), .out_pres (f_pres), .out_div (f_div)
  );

  // divide pres<<1 when the top bit is clear, else pres then double
  logic        f_zero, f_big;
  logic [31:0] num;
  assign f_zero = (f_div == '0);
  assign f_big  = f_pres[31];
  assign num    = f_big ? f_pres : {f_pres[30:0], 1'b0};

  logic        d_vld;
  logic [31:0] d_quo;
  logic [65:0] d_side;
  bsc_udiv #(.SideW(66)) u_div (
    .clk, .rst_n, .en,
    .in_vld  (f_vld),
    .in_num  (num),
    .in_den  (f_div),
    .in_side ({f_big, f_zero, f_temp, f_pres}),
    .out_vld (d_vld),
    .out_quo (d_quo),
    .out_side(d_side)
  );

  logic [31:0] q_pres;
  assign q_pres = d_side[64] ? d_side[31:0]
                : (d_side[65] ? {d_quo[30:0], 1'b0} : d_quo);

  logic        b_vld, b_zero;
  logic [31:0] b_temp, b_pres;
  bsc_back u_back (
    .clk, .rst_n, .en,
    .in_vld  (d_vld),
    .in_temp (d_side[63:32]),
    .in_pres (q_pres),
    .in_zero (d_side[64]),
    .coef,
    .out_vld (b_vld), .out_temp (b_temp), .out_pres (b_pres), .out_zero (b_zero)
  );

  logic out_valid_r;
  logic [31:0] temp_r, pres_r;
  logic zero_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= b_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temp_r <= b_temp;
      pres_r <= b_pres;
      zero_r <= b_zero;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_pressure_pa       = pres_r;
  assign out_divisor_zero      = zero_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_pa))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input taken while output stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && f_vld |=> u_div.side_r[0][64] == $past(f_zero))
    else $error("zero flag lost entering divider");

endmodule
`default_nettype wire

>>> src/bsc_udiv.sv
// Pipelined unsigned 32/32 divider, one quotient bit per stage, with side payload
`timescale 1ns / 1ps
`default_nettype none
module bsc_udiv import bsc_pkg::*; #(
  parameter int SideW = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [DivW-1:0]  in_num,
  input  wire logic [DivW-1:0]  in_den,
  input  wire logic [SideW-1:0] in_side,
  output logic                  out_vld,
  output logic [DivW-1:0]       out_quo,
  output logic [SideW-1:0]      out_side
);

  logic [DivW:0]      vld_r;
  logic [DivW-1:0]    rem_r  [DivW+1];
  logic [DivW-1:0]    quo_r  [DivW+1];
  logic [DivW-1:0]    den_r  [DivW+1];
  logic [SideW-1:0]   side_r [DivW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DivW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= in_num;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [DivW:0]   trial;
    logic [DivW:0]   shifted;
    assign shifted = {rem_r[s], quo_r[s][DivW-1]};
    assign trial   = shifted - {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DivW]) begin
          rem_r[s+1] <= trial[DivW-1:0];
          quo_r[s+1] <= {quo_r[s][DivW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= shifted[DivW-1:0];
          quo_r[s+1] <= {quo_r[s][DivW-2:0], 1'b0};
        end
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld  = vld_r[DivW];
  assign out_quo  = quo_r[DivW];
  assign out_side = side_r[DivW];

endmodule
`default_nettype wire

>>> src/bsc_front.sv
// Front pipeline: fine temperature, compensated temperature, divisor and dividend
`timescale 1ns / 1ps
`default_nettype none
module bsc_front import bsc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [RawW-1:0] in_ut,
  input  wire logic [RawW-1:0] in_up,
  input  wire coef_t           coef,
  output logic                 out_vld,
  output logic signed [31:0]   out_temp,
  output logic [31:0]          out_pres,
  output logic [31:0]          out_div
);

  // stage 1
  logic [5:0] vld_r;
  logic signed [31:0] s1_x_r, s1_d_r;
  logic [RawW-1:0]    s1_up_r, s2_up_r, s3_up_r, s4_up_r, s5_up_r;
  // stage 2
  logic signed [31:0] s2_a_r, s2_dd_r;
  // stage 3
  logic signed [31:0] s3_a_r, s3_b_r;
  // stage 4
  logic signed [31:0] s4_fine_r;
  // stage 5
  logic signed [31:0] s5_temp_r, s5_pa_r, s5_qq_r;
  // stage 6
  logic signed [31:0] s6_temp_r, s6_b1_r, s6_b2_r, s6_a1_r, s6_a2_r, s6_p4_r;
  logic [RawW-1:0]    s6_up_r;
  // stage 7
  logic signed [31:0] s7_temp_r, s7_b_r, s7_a_r;
  logic [RawW-1:0]    s7_up_r;
  logic [1:0]         vld2_r;
  // stage 8
  logic signed [31:0] s8_temp_r, s8_pb_r, s8_div_r;

  logic signed [31:0] ut_s, t1_s, x_n, d_n, a_n, dd_n, b_n, fine_n, tmp5, q_n, pa_n, qq_n;
  logic signed [31:0] bsum, asum, a3, pb_n;
  logic signed [31:0] bval_n, aval_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld2_r <= '0;
    end else if (en) begin
      vld_r  <= {vld_r[4:0], in_vld};
      vld2_r <= {vld2_r[0], vld_r[5]};
    end
  end

  always_comb begin
    ut_s  = {12'd0, in_ut};
    t1_s  = {16'd0, coef.t1};
    x_n   = (ut_s >>> 3) - (t1_s <<< 1);
    d_n   = (ut_s >>> 4) - t1_s;
    a_n   = sdiv_pow2(s1_x_r * 32'(coef.t2), 11);
    dd_n  = sdiv_pow2(s1_d_r * s1_d_r, 12);
    b_n   = sdiv_pow2(s2_dd_r * 32'(coef.t3), 14);
    fine_n = s3_a_r + s3_b_r;
    tmp5  = s4_fine_r * 32'sd5 + 32'sd128;
    pa_n  = sdiv_pow2(s4_fine_r, 1) - 32'sd64000;
    q_n   = sdiv_pow2(pa_n, 2);
    qq_n  = q_n * q_n;
    bsum  = s6_b1_r + s6_b2_r;
    bval_n = sdiv_pow2(bsum, 2) + s6_p4_r;
    asum  = sdiv_pow2(s6_a1_r, 3) + sdiv_pow2(s6_a2_r, 1);
    aval_n = sdiv_pow2(asum, 18);
    a3    = (32'sd32768 + s7_a_r) * {16'd0, coef.p1};
    pb_n  = 32'sd1048576 - {12'd0, s7_up_r} - sdiv_pow2(s7_b_r, 12);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r <= x_n;
      s1_d_r <= d_n;
      s1_up_r <= in_up;
      s2_a_r <= a_n;
      s2_dd_r <= dd_n;
      s2_up_r <= s1_up_r;
      s3_a_r <= s2_a_r;
      s3_b_r <= b_n;
      s3_up_r <= s2_up_r;
      s4_fine_r <= fine_n;
      s4_up_r <= s3_up_r;
      s5_temp_r <= sdiv_pow2(tmp5, 8);
      s5_pa_r <= pa_n;
      s5_qq_r <= qq_n;
      s5_up_r <= s4_up_r;
      s6_temp_r <= s5_temp_r;
      s6_b1_r <= sdiv_pow2(s5_qq_r, 11) * 32'(coef.p6);
      s6_b2_r <= (s5_pa_r * 32'(coef.p5)) <<< 1;
      s6_a1_r <= 32'(coef.p3) * sdiv_pow2(s5_qq_r, 13);
      s6_a2_r <= 32'(coef.p2) * s5_pa_r;
      s6_p4_r <= 32'(coef.p4) <<< 16;
      s6_up_r <= s5_up_r;
      s7_temp_r <= s6_temp_r;
      s7_b_r <= bval_n;
      s7_a_r <= aval_n;
      s7_up_r <= s6_up_r;
      s8_temp_r <= s7_temp_r;
      s8_pb_r <= pb_n;
      s8_div_r <= sdiv_pow2(a3, 15);
    end
  end

  // stage 9: times 3125
  logic signed [31:0] s9_temp_r, s9_pres_r, s9_div_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_temp_r <= s8_temp_r;
      s9_pres_r <= s8_pb_r * 32'sd3125;
      s9_div_r  <= s8_div_r;
    end
  end
  logic vld9_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld9_r <= 1'b0;
    else if (en) vld9_r <= vld2_r[1];
  end

  assign out_vld  = vld9_r;
  assign out_temp = s9_temp_r;
  assign out_pres = s9_pres_r;
  assign out_div  = s9_div_r;

endmodule
`default_nettype wire

>>> src/bsc_back.sv
// Back pipeline: second-order pressure correction after the division
`timescale 1ns / 1ps
`default_nettype none
module bsc_back import bsc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [31:0]   in_temp,
  input  wire logic [31:0]   in_pres,
  input  wire logic          in_zero,
  input  wire coef_t         coef,
  output logic               out_vld,
  output logic [31:0]        out_temp,
  output logic [31:0]        out_pres,
  output logic               out_zero
);

  logic [2:0]  vld_r;
  logic [31:0] t1_r, t2_r, t3_r, p1_r, p2_r, p3_r, sq_r, m9_r, m8_r;
  logic        z1_r, z2_r, z3_r;
  logic [28:0] p8;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[1:0], in_vld};
  end

  assign p8 = in_pres[31:3];

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= in_temp; p1_r <= in_pres; z1_r <= in_zero;
      sq_r <= ({3'd0, p8} * {3'd0, p8}) >> 13;
      t2_r <= t1_r; p2_r <= p1_r; z2_r <= z1_r;
      m9_r <= sdiv_pow2(32'(coef.p9) * $signed(sq_r), 12);
      m8_r <= sdiv_pow2($signed({2'd0, p1_r[31:2]}) * 32'(coef.p8), 13);
      t3_r <= t2_r; z3_r <= z2_r;
      p3_r <= z2_r ? p2_r
                   : p2_r + sdiv_pow2(m9_r + m8_r + 32'(coef.p7), 4);
    end
  end

  assign out_vld  = vld_r[2];
  assign out_temp = t3_r;
  assign out_pres = p3_r;
  assign out_zero = z3_r;

endmodule
`default_nettype wire

>>> bench/tb_barometric_sensor_compensation.sv
// Testbench: checks barometric compensation results against an in-bench model
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation;
  import bsc_pkg::*;

  typedef struct {
    logic signed [31:0] temp;
    logic [31:0]        pres;
    logic               dz;
  } reading_t;

  typedef struct {
    logic [19:0] rt;
    logic [19:0] rp;
    bit          typed;
    reading_t    want;
  } row_t;

  localparam int Latency   = 46;
  localparam int WatchLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [RawW-1:0] in_raw_temperature, in_raw_pressure;
  logic signed [31:0] out_temperature_centi;
  logic [31:0] out_pressure_pa;
  logic out_divisor_zero;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  logic [47:0] coef [4];
  reading_t pending_readings[$];
  row_t     typed_rows[$];
  int errors, in_count, out_count, cfg_count, quiet, dz_seen;
  bit no_idle;

  barometric_sensor_compensation DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int sfield(logic [47:0] r, int pos);
    logic signed [15:0] v;
    v = r[pos +: 16];
    return int'(v);
  endfunction

  // 32-bit wrapping arithmetic; int division truncates toward zero
  function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
    int ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    int a, b, d, q, fine;
    int unsigned pres, dv;
    reading_t r;
    ut = int'({12'd0, rt});
    up = int'({12'd0, rp});
    t1 = int'({16'd0, coef[REG_TEMP][15:0]});
    t2 = sfield(coef[REG_TEMP], 16);
    t3 = sfield(coef[REG_TEMP], 32);
    p1 = int'({16'd0, coef[REG_PRESA][15:0]});
    p2 = sfield(coef[REG_PRESA], 16);
    p3 = sfield(coef[REG_PRESA], 32);
    p4 = sfield(coef[REG_PRESB], 0);
    p5 = sfield(coef[REG_PRESB], 16);
    p6 = sfield(coef[REG_PRESB], 32);
    p7 = sfield(coef[REG_PRESC], 0);
    p8 = sfield(coef[REG_PRESC], 16);
    p9 = sfield(coef[REG_PRESC], 32);
    a = ((ut / 8 - t1 * 2) * t2) / 2048;
    d = ut / 16 - t1;
    b = (((d * d) / 4096) * t3) / 16384;
    fine = a + b;
    r.temp = (fine * 5 + 128) / 256;
    a = fine / 2 - 64000;
    q = a / 4;
    b = ((q * q) / 2048) * p6;
    b = b + (a * p5) * 2;
    b = b / 4 + p4 * 65536;
    a = ((p3 * ((q * q) / 8192)) / 8 + (p2 * a) / 2) / 262144;
    a = ((32768 + a) * p1) / 32768;
    pres = $unsigned((1048576 - up - b / 4096) * 3125);
    r.dz = (a == 0);
    if (!r.dz) begin
      dv = $unsigned(a);
      if (pres < 32'h8000_0000) pres = (pres << 1) / dv;
      else pres = (pres / dv) * 2;
      a = (p9 * $signed(((pres / 8) * (pres / 8)) / 8192)) / 4096;
      b = ($signed(pres / 4) * p8) / 8192;
      pres = pres + $unsigned((a + b + p7) / 16);
    end
    r.pres = pres;
    return r;
  endfunction

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request bookkeeping, result checking and watchdog
  always @(posedge clk) begin
    reading_t want, got;
    row_t row;
    if (rst_n) begin
      quiet = quiet + 1;
      if (cfg_valid && cfg_ready) begin
        coef[cfg_index] = cfg_data;
        cfg_count = cfg_count + 1;
        quiet = 0;
      end
      if (in_valid && in_ready) begin
        want = compensate(in_raw_temperature, in_raw_pressure);
        if (typed_rows.size() > 0) begin
          row = typed_rows.pop_front();
          if (row.typed) want = row.want;
        end
        pending_readings.push_back(want);
        in_count = in_count + 1;
        quiet = 0;
      end
      if (out_valid && out_ready) begin
        quiet = 0;
        out_count = out_count + 1;
        got.temp = out_temperature_centi;
        got.pres = out_pressure_pa;
        got.dz = out_divisor_zero;
        if (got.dz) dz_seen = dz_seen + 1;
        if (pending_readings.size() == 0) begin
          $error("unexpected result: temperature_centi %0d pressure_pa %0d", got.temp,
                 got.pres);
          errors = errors + 1;
        end else begin
          want = pending_readings.pop_front();
          if (got.temp !== want.temp) begin
            $error("temperature_centi: expected %0d, got %0d", want.temp, got.temp);
            errors = errors + 1;
          end
          if (got.pres !== want.pres) begin
            $error("pressure_pa: expected %0d, got %0d", want.pres, got.pres);
            errors = errors + 1;
          end
          if (got.dz !== want.dz) begin
            $error("divisor_zero: expected %0d, got %0d", want.dz, got.dz);
            errors = errors + 1;
          end
        end
      end
      if (quiet >= WatchLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int g;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      g = gap();
      if (g > 0) begin
        out_ready = 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // called at a falling edge; leaves in_valid high after acceptance
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    int g, n;
    g = gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_raw_temperature = rt;
    in_raw_pressure = rp;
    in_valid = 1'b1;
    n = in_count;
    do @(negedge clk); while (in_count == n);
  endtask

  task automatic write_coef(reg_idx_t idx, logic [47:0] val);
    int n;
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    n = cfg_count;
    do @(negedge clk); while (cfg_count == n);
  endtask

  // drain, wait out the pipeline, then load a full set of coefficients
  task automatic load_coefs(logic [47:0] t, logic [47:0] a, logic [47:0] b, logic [47:0] c);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    write_coef(REG_TEMP, t);
    write_coef(REG_PRESA, a);
    write_coef(REG_PRESB, b);
    write_coef(REG_PRESC, c);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [19:0] near(int centre, int span);
    return 20'(centre + $urandom_range(0, 2 * span) - span);
  endfunction

  localparam logic [47:0] TypT = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] TypB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] TypC = {16'd6000, 16'hC6F8, 16'd15500};

  row_t rows[$];

  initial begin
    logic [19:0] rt, rp;
    int r, k;
    errors = 0; in_count = 0; out_count = 0; cfg_count = 0; quiet = 0; dz_seen = 0;
    no_idle = 0;
    for (int i = 0; i < 4; i++) coef[i] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_raw_temperature = '0; in_raw_pressure = '0;
    cfg_valid = 1'b0; cfg_index = REG_TEMP; cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients: P1 is zero, so the divisor is zero and the
    // intermediate (2^20 - raw) * 3125 comes out
    rows = '{
      '{20'h00000, 20'h00000, 1'b1, '{32'sd0, 32'd3276800000, 1'b1}},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, '{32'sd0, 32'd3125, 1'b1}},
      '{20'h00000, 20'hFFFFF, 1'b1, '{32'sd0, 32'd3125, 1'b1}},
      '{20'hFFFFF, 20'h00000, 1'b1, '{32'sd0, 32'd3276800000, 1'b1}},
      '{20'h80000, 20'h7FFFF, 1'b0, '{0, 0, 0}},
      '{20'h55555, 20'hAAAAA, 1'b0, '{0, 0, 0}},
      '{20'hAAAAA, 20'h55555, 1'b0, '{0, 0, 0}},
      '{20'h7EED0, 20'h655AC, 1'b0, '{0, 0, 0}}
    };
    foreach (rows[i]) begin
      typed_rows.push_back(rows[i]);
      send_sample(rows[i].rt, rows[i].rp);
    end

    // typical calibration, then extremes, a typical set with P1 zero, then random and typical sets
    for (int ph = 1; ph <= 11; ph++) begin
      case (ph)
        1, 10: load_coefs(TypT, TypA, TypB, TypC);
        2: load_coefs('1, '1, '1, '1);
        3: load_coefs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                      {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        4: load_coefs({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h0001},
                      {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
        5: load_coefs(TypT, {TypA[47:16], 16'd0}, TypB, TypC);
        default: load_coefs(rand48(), rand48(), rand48(), rand48());
      endcase
      no_idle = (ph == 6);
      // directed rows under typical calibration: extremes of both readings and one typical reading
      if (ph == 1) begin
        send_sample(20'h00000, 20'h00000);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'h7EED0, 20'h655AC);
      end
      k = (ph >= 6 && ph <= 9) ? 120 : 170;
      for (int i = 0; i < k; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rt = near(519888, 40000);
          rp = near(415148, 90000);
        end else if (r < 95) begin
          rt = 20'($urandom());
          rp = 20'($urandom());
        end else begin
          rt = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
          rp = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
        end
        send_sample(rt, rp);
      end
    end
    in_valid = 1'b0;

    while (pending_readings.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d results never arrived", pending_readings.size());
      errors = errors + 1;
    end
    $display("Run: %0d samples under 12 coefficient sets, %0d results checked", in_count,
             out_count);
    $display("Run: %0d results with a zero divisor, %0d mismatches", dz_seen, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
